>>> src/dtz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtz_pkg;

   localparam int SLOTS         = 4;
   localparam int SLOT_BITS     = 16;
   localparam int IDX_BITS      = 2;
   localparam int CNT_BITS      = 3;
   localparam int ZONE_BITS     = 4;
   localparam int DEB_BITS      = 16;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_UP_THR,
      CSR_UP_DEB,
      CSR_UP_META,
      CSR_DN_THR,
      CSR_DN_DEB,
      CSR_DN_META,
      CSR_INIT_VALUE,
      CSR_INIT_ZONE
   } csr_index_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIR,
      ST_T_CUR,
      ST_T_OLD,
      ST_BACK,
      ST_SETTLE,
      ST_ELAPSED,
      ST_CONFIRM,
      ST_SHIFT_GAP,
      ST_SHIFT_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                up;
      logic [IDX_BITS-1:0] idx;
   } rule_sel_type;

endpackage

`default_nettype wire

>>> src/dtz_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module dtz_alu
   import dtz_pkg::*;
#(
   parameter int WIDTH = 33
) (
   input  alu_op_type       op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] res
);

   always_comb begin
      case (op)
         ALU_SUB: res = a - b;
         ALU_ADD: res = a + b;
         default: res = a + b;
      endcase
   end

endmodule

`default_nettype wire

>>> src/dtz_rules.sv
`timescale 1ns / 1ps
`default_nettype none

module dtz_rules
   import dtz_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_RULES   = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  csr_index_type                 csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  rule_sel_type                  sel,
   output logic signed [SAMPLE_BITS-1:0] thr,
   output logic [DEB_BITS-1:0]           deb,
   output logic [ZONE_BITS-1:0]          target,
   output logic [CNT_BITS-1:0]           up_count,
   output logic [CNT_BITS-1:0]           dn_count
);

   logic signed [SAMPLE_BITS-1:0] up_thr_ff  [SLOTS];
   logic signed [SAMPLE_BITS-1:0] dn_thr_ff  [SLOTS];
   logic [DEB_BITS-1:0]           up_deb_ff  [SLOTS];
   logic [DEB_BITS-1:0]           dn_deb_ff  [SLOTS];
   logic [ZONE_BITS-1:0]          up_zone_ff [SLOTS];
   logic [ZONE_BITS-1:0]          dn_zone_ff [SLOTS];
   logic [CNT_BITS-1:0]           up_cnt_ff;
   logic [CNT_BITS-1:0]           dn_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            up_thr_ff[i]  <= '0;
            dn_thr_ff[i]  <= '0;
            up_deb_ff[i]  <= '0;
            dn_deb_ff[i]  <= '0;
            up_zone_ff[i] <= '0;
            dn_zone_ff[i] <= '0;
         end
         up_cnt_ff <= CNT_BITS'(1);
         dn_cnt_ff <= CNT_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_UP_THR: begin
               for (int i = 0; i < SLOTS; i++)
                  up_thr_ff[i] <= csr_wdata[i*SLOT_BITS +: SAMPLE_BITS];
            end
            CSR_UP_DEB: begin
               for (int i = 0; i < SLOTS; i++)
                  up_deb_ff[i] <= csr_wdata[i*SLOT_BITS +: DEB_BITS];
            end
            CSR_UP_META: begin
               up_cnt_ff <= csr_wdata[CNT_BITS-1:0];
               for (int i = 0; i < SLOTS; i++)
                  up_zone_ff[i] <= csr_wdata[CNT_BITS + i*ZONE_BITS +: ZONE_BITS];
            end
            CSR_DN_THR: begin
               for (int i = 0; i < SLOTS; i++)
                  dn_thr_ff[i] <= csr_wdata[i*SLOT_BITS +: SAMPLE_BITS];
            end
            CSR_DN_DEB: begin
               for (int i = 0; i < SLOTS; i++)
                  dn_deb_ff[i] <= csr_wdata[i*SLOT_BITS +: DEB_BITS];
            end
            CSR_DN_META: begin
               dn_cnt_ff <= csr_wdata[CNT_BITS-1:0];
               for (int i = 0; i < SLOTS; i++)
                  dn_zone_ff[i] <= csr_wdata[CNT_BITS + i*ZONE_BITS +: ZONE_BITS];
            end
            default: ;
         endcase
      end
   end

   // counts above the supported rule number clamp to it
   assign up_count = (up_cnt_ff > CNT_BITS'(MAX_RULES)) ? CNT_BITS'(MAX_RULES) : up_cnt_ff;
   assign dn_count = (dn_cnt_ff > CNT_BITS'(MAX_RULES)) ? CNT_BITS'(MAX_RULES) : dn_cnt_ff;

   assign thr    = sel.up ? up_thr_ff[sel.idx]  : dn_thr_ff[sel.idx];
   assign deb    = sel.up ? up_deb_ff[sel.idx]  : dn_deb_ff[sel.idx];
   assign target = sel.up ? up_zone_ff[sel.idx] : dn_zone_ff[sel.idx];

endmodule

`default_nettype wire

>>> src/debounced_threshold_zone_classifier.sv
// Debounced multi-threshold zone classifier, one channel.
// Request channel (req_valid / req_stall): one item carries a sample, its
// valid flag and the current tick count. Response channel (rsp_valid /
// rsp_stall): one item per request with the confirmed zone and whether a
// transition still waits for its debounce time to pass.
// Configuration: csr_we with csr_index and csr_wdata writes one rule or
// start register; writing the initial value or initial zone restarts the
// channel and drops any pending transition. One shared add/subtract unit,
// stepped by a sequencer, does every sample, threshold and tick
// computation. An invalid sample steps through tick gap, debounce shift and
// output; a valid one through direction, new and old sample checks per rule
// (four rules, searched at most twice), back-check, settle, debounce check
// and output. req_stall is high from acceptance until the result is loaded
// into the output register; the next item can be taken in the cycle after.
// A result waiting on rsp_stall does not block acceptance of the next item,
// but that item cannot finish until the output register is free.
// Reset: synchronous, active high; rules, start values and channel state
// return to their reset values and no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module debounced_threshold_zone_classifier
   import dtz_pkg::*;
#(
   parameter int MAX_RULES   = 4,
   parameter int SAMPLE_BITS = 16,
   parameter int TICK_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_sample_valid,
   input  logic [TICK_BITS-1:0]          req_now_ticks,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ZONE_BITS-1:0]          rsp_zone,
   output logic                          rsp_debounce_pending,
   input  logic                          csr_we,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int CW = TICK_BITS + 1;

   state_type state_ff, state_in;

   // channel state
   logic signed [SAMPLE_BITS-1:0] prev_sample_ff, prev_sample_in;
   logic [TICK_BITS-1:0]          prev_tick_ff, prev_tick_in;
   logic                          pend_act_ff, pend_act_in;
   logic                          pend_up_ff, pend_up_in;
   logic [IDX_BITS-1:0]           pend_rule_ff, pend_rule_in;
   logic signed [SAMPLE_BITS-1:0] pend_start_ff, pend_start_in;
   logic [TICK_BITS-1:0]          deb_start_ff, deb_start_in;
   logic [ZONE_BITS-1:0]          zone_ff, zone_in;
   logic signed [SAMPLE_BITS-1:0] init_value_ff, init_value_in;
   logic [ZONE_BITS-1:0]          init_zone_ff, init_zone_in;

   // per-item working registers
   logic signed [SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic signed [SAMPLE_BITS-1:0] old_ff, old_in;
   logic [TICK_BITS-1:0]          now_ff, now_in;
   logic [TICK_BITS-1:0]          elapsed_ff, elapsed_in;
   logic [IDX_BITS-1:0]           idx_ff, idx_in;
   logic                          up_dir_ff, up_dir_in;
   logic                          pass2_ff, pass2_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ZONE_BITS-1:0] rsp_zone_ff, rsp_zone_in;
   logic                 rsp_pend_ff, rsp_pend_in;

   csr_index_type csr_idx;
   rule_sel_type  sel;
   logic signed [SAMPLE_BITS-1:0] thr;
   logic [DEB_BITS-1:0]  deb;
   logic [ZONE_BITS-1:0] target;
   logic [CNT_BITS-1:0]  up_count, dn_count;
   logic [CNT_BITS-1:0]  up_count_m1;

   alu_op_type    alu_op;
   logic [CW-1:0] alu_a, alu_b, alu_res;
   logic          res_neg, res_zero;

   logic [CW-1:0] cur_x, old_x, thr_x;
   logic          idx_last;
   logic [IDX_BITS-1:0] idx_step;
   logic          srch_hit, srch_miss;

   assign csr_idx = csr_index_type'(csr_index);

   dtz_rules #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_RULES   (MAX_RULES)
   ) u_rules (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_idx),
      .csr_wdata (csr_wdata),
      .sel       (sel),
      .thr       (thr),
      .deb       (deb),
      .target    (target),
      .up_count  (up_count),
      .dn_count  (dn_count)
   );

   dtz_alu #(
      .WIDTH (CW)
   ) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   // search walks the current direction; back-check and confirm use the pending rule
   always_comb begin
      if (state_ff == ST_T_CUR || state_ff == ST_T_OLD) begin
         sel.up  = up_dir_ff;
         sel.idx = idx_ff;
      end else begin
         sel.up  = pend_up_ff;
         sel.idx = pend_rule_ff;
      end
   end

   assign cur_x = {{(CW-SAMPLE_BITS){cur_ff[SAMPLE_BITS-1]}}, cur_ff};
   assign old_x = {{(CW-SAMPLE_BITS){old_ff[SAMPLE_BITS-1]}}, old_ff};
   assign thr_x = {{(CW-SAMPLE_BITS){thr[SAMPLE_BITS-1]}}, thr};

   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         ST_DIR: begin
            alu_a = cur_x;
            alu_b = old_x;
         end
         ST_T_CUR, ST_BACK: begin
            alu_a = cur_x;
            alu_b = thr_x;
         end
         ST_T_OLD: begin
            alu_a = old_x;
            alu_b = thr_x;
         end
         ST_ELAPSED: begin
            alu_a = {1'b0, now_ff};
            alu_b = {1'b0, deb_start_ff};
         end
         ST_CONFIRM: begin
            alu_a = {1'b0, elapsed_ff};
            alu_b = {{(CW-DEB_BITS){1'b0}}, deb};
         end
         ST_SHIFT_GAP: begin
            alu_a = {1'b0, now_ff};
            alu_b = {1'b0, prev_tick_ff};
         end
         ST_SHIFT_ADD: begin
            alu_op = ALU_ADD;
            alu_a  = {1'b0, deb_start_ff};
            alu_b  = {1'b0, elapsed_ff};
         end
         default: ;
      endcase
   end

   assign res_neg  = alu_res[CW-1];
   assign res_zero = (alu_res == '0);

   assign up_count_m1 = up_count - CNT_BITS'(1);
   assign idx_last = up_dir_ff ? (idx_ff == '0)
                               : (({1'b0, idx_ff} + CNT_BITS'(1)) == dn_count);
   assign idx_step = up_dir_ff ? (idx_ff - IDX_BITS'(1)) : (idx_ff + IDX_BITS'(1));

   always_comb begin
      state_in       = state_ff;
      prev_sample_in = prev_sample_ff;
      prev_tick_in   = prev_tick_ff;
      pend_act_in    = pend_act_ff;
      pend_up_in     = pend_up_ff;
      pend_rule_in   = pend_rule_ff;
      pend_start_in  = pend_start_ff;
      deb_start_in   = deb_start_ff;
      zone_in        = zone_ff;
      init_value_in  = init_value_ff;
      init_zone_in   = init_zone_ff;
      cur_in         = cur_ff;
      old_in         = old_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      idx_in         = idx_ff;
      up_dir_in      = up_dir_ff;
      pass2_in       = pass2_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_zone_in    = rsp_zone_ff;
      rsp_pend_in    = rsp_pend_ff;
      srch_hit       = 1'b0;
      srch_miss      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_sample;
               now_in   = req_now_ticks;
               old_in   = prev_sample_ff;
               pass2_in = 1'b0;
               state_in = req_sample_valid ? ST_DIR : ST_SHIFT_GAP;
            end
         end
         ST_DIR: begin
            if (res_zero) begin
               srch_miss = 1'b1;
            end else if (!res_neg) begin
               up_dir_in = 1'b1;
               idx_in    = up_count_m1[IDX_BITS-1:0];
               if (up_count == '0) srch_miss = 1'b1;
               else state_in = ST_T_CUR;
            end else begin
               up_dir_in = 1'b0;
               idx_in    = '0;
               if (dn_count == '0) srch_miss = 1'b1;
               else state_in = ST_T_CUR;
            end
         end
         ST_T_CUR: begin
            // sample is beyond the threshold in the search direction
            if (up_dir_ff ? (!res_neg && !res_zero) : res_neg) begin
               state_in = ST_T_OLD;
            end else if (idx_last) begin
               srch_miss = 1'b1;
            end else begin
               idx_in   = idx_step;
               state_in = ST_T_CUR;
            end
         end
         ST_T_OLD: begin
            // origin was on the near side of the threshold
            if (up_dir_ff ? (res_neg || res_zero) : !res_neg) begin
               srch_hit = 1'b1;
            end else if (idx_last) begin
               srch_miss = 1'b1;
            end else begin
               idx_in   = idx_step;
               state_in = ST_T_CUR;
            end
         end
         ST_BACK: begin
            if (pend_up_ff ? (res_neg || res_zero) : !res_neg) begin
               pass2_in = 1'b1;
               old_in   = pend_start_ff;
               state_in = ST_DIR;
            end else begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            prev_sample_in = cur_ff;
            state_in       = pend_act_ff ? ST_ELAPSED : ST_OUT;
         end
         ST_ELAPSED: begin
            elapsed_in = alu_res[TICK_BITS-1:0];
            state_in   = ST_CONFIRM;
         end
         ST_CONFIRM: begin
            if (!res_neg) begin
               zone_in     = target;
               pend_act_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_SHIFT_GAP: begin
            elapsed_in = alu_res[TICK_BITS-1:0];
            state_in   = ST_SHIFT_ADD;
         end
         ST_SHIFT_ADD: begin
            deb_start_in = alu_res[TICK_BITS-1:0];
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_zone_in  = zone_ff;
               rsp_pend_in  = pend_act_ff;
               prev_tick_in = now_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (srch_hit) begin
         pend_up_in   = up_dir_ff;
         pend_rule_in = idx_ff;
         if (!pass2_ff) begin
            pend_act_in   = 1'b1;
            pend_start_in = old_ff;
            deb_start_in  = now_ff;
         end
         state_in = ST_SETTLE;
      end

      if (srch_miss) begin
         if (pass2_ff) begin
            pend_act_in = 1'b0;
            state_in    = ST_SETTLE;
         end else begin
            state_in = pend_act_ff ? ST_BACK : ST_SETTLE;
         end
      end

      // channel restart on a write of either start register
      if (csr_we) begin
         case (csr_idx)
            CSR_INIT_VALUE: begin
               init_value_in  = csr_wdata[SAMPLE_BITS-1:0];
               prev_sample_in = csr_wdata[SAMPLE_BITS-1:0];
               zone_in        = init_zone_ff;
               pend_act_in    = 1'b0;
            end
            CSR_INIT_ZONE: begin
               init_zone_in   = csr_wdata[ZONE_BITS-1:0];
               zone_in        = csr_wdata[ZONE_BITS-1:0];
               prev_sample_in = init_value_ff;
               pend_act_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= '0;
         prev_tick_ff   <= '0;
         pend_act_ff    <= 1'b0;
         pend_up_ff     <= 1'b0;
         pend_rule_ff   <= '0;
         pend_start_ff  <= '0;
         deb_start_ff   <= '0;
         zone_ff        <= '0;
         init_value_ff  <= '0;
         init_zone_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_sample_ff <= prev_sample_in;
         prev_tick_ff   <= prev_tick_in;
         pend_act_ff    <= pend_act_in;
         pend_up_ff     <= pend_up_in;
         pend_rule_ff   <= pend_rule_in;
         pend_start_ff  <= pend_start_in;
         deb_start_ff   <= deb_start_in;
         zone_ff        <= zone_in;
         init_value_ff  <= init_value_in;
         init_zone_ff   <= init_zone_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      old_ff      <= old_in;
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      idx_ff      <= idx_in;
      up_dir_ff   <= up_dir_in;
      pass2_ff    <= pass2_in;
      rsp_zone_ff <= rsp_zone_in;
      rsp_pend_ff <= rsp_pend_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_zone             = rsp_zone_ff;
   assign rsp_debounce_pending = rsp_pend_ff;

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output step");

   a_idle_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !req_valid |=> (state_ff == ST_IDLE))
      else $error("sequencer left idle without an item");

   a_zone_source : assert property (@(posedge clock) disable iff (reset)
      !$stable(zone_ff) |-> $past(state_ff == ST_CONFIRM || csr_we || reset))
      else $error("zone changed outside confirm or restart");

   a_restart_clears : assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_idx == CSR_INIT_VALUE || csr_idx == CSR_INIT_ZONE) |=> !pend_act_ff)
      else $error("channel restart left a transition pending");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import dtz_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [ZONE_BITS-1:0] zone;
      logic                 pending;
   } zone_report_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [15:0]       req_sample = '0;
   logic                     req_sample_valid = 1'b0;
   logic [31:0]              req_now_ticks = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ZONE_BITS-1:0]     rsp_zone;
   logic                     rsp_debounce_pending;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   debounced_threshold_zone_classifier uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample           (req_sample),
      .req_sample_valid     (req_sample_valid),
      .req_now_ticks        (req_now_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_zone             (rsp_zone),
      .rsp_debounce_pending (rsp_debounce_pending),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // rule registers as the classifier sees them
   logic [63:0]        up_thr_reg, up_deb_reg, dn_thr_reg, dn_deb_reg;
   logic [18:0]        up_meta_reg, dn_meta_reg;
   logic signed [15:0] init_value_reg;
   logic [3:0]         init_zone_reg;

   // channel state
   logic signed [15:0] last_sample;
   logic [31:0]        last_tick;
   logic               pend_active, pend_up;
   logic [1:0]         pend_rule;
   logic signed [15:0] pend_origin;
   logic [31:0]        deb_start;
   logic [3:0]         zone_now;

   zone_report_t expected_reports[$];

   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   int          long_hold = 0;
   logic [31:0] tick_now = '0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          zone_changes = 0;
   int          mismatches = 0;
   int          reg_writes = 0;
   int          cycle_count = 0;

   function automatic logic signed [15:0] slot_value(logic [63:0] slots, int i);
      return slots[16*i +: 16];
   endfunction

   function automatic logic [15:0] debounce_of(logic [63:0] slots, int i);
      return slots[16*i +: 16];
   endfunction

   function automatic logic [3:0] target_of(logic [18:0] meta, int i);
      return meta[4*i+3 +: 4];
   endfunction

   function automatic int rule_limit(logic [18:0] meta);
      return (meta[2:0] > 3'd4) ? 4 : int'(meta[2:0]);
   endfunction

   function automatic logic [63:0] pack4(int a, int b, int c, int d);
      return {16'(d), 16'(c), 16'(b), 16'(a)};
   endfunction

   function automatic logic [63:0] meta_pack(int count, int t0, int t1, int t2, int t3);
      return {45'd0, 4'(t3), 4'(t2), 4'(t1), 4'(t0), 3'(count)};
   endfunction

   function automatic void restart_channel();
      last_sample = init_value_reg;
      zone_now    = init_zone_reg;
      pend_active = 1'b0;
   endfunction

   // upward: highest slot first; downward: lowest slot first; first hit wins
   function automatic bit find_crossing(input logic signed [15:0] cur,
                                        input logic signed [15:0] origin,
                                        output logic [1:0] rule, output logic up);
      bit hit;
      int n;
      hit  = 1'b0;
      rule = '0;
      up   = 1'b0;
      if (cur > origin) begin
         n = rule_limit(up_meta_reg);
         for (int k = n - 1; k >= 0; k--)
            if (!hit && cur > slot_value(up_thr_reg, k) && origin <= slot_value(up_thr_reg, k)) begin
               hit  = 1'b1;
               rule = 2'(k);
               up   = 1'b1;
            end
      end else if (cur < origin) begin
         n = rule_limit(dn_meta_reg);
         for (int k = 0; k < n; k++)
            if (!hit && cur < slot_value(dn_thr_reg, k) && origin >= slot_value(dn_thr_reg, k)) begin
               hit  = 1'b1;
               rule = 2'(k);
               up   = 1'b0;
            end
      end
      return hit;
   endfunction

   function automatic zone_report_t classify_sample(logic signed [15:0] cur, logic ok,
                                                    logic [31:0] now);
      logic [1:0]   rule;
      logic         up, back, hit;
      logic [31:0]  elapsed;
      logic [15:0]  need;
      zone_report_t rpt;
      if (ok) begin
         hit = find_crossing(cur, last_sample, rule, up);
         if (hit) begin
            pend_active = 1'b1;
            pend_up     = up;
            pend_rule   = rule;
            pend_origin = last_sample;
            deb_start   = now;
         end else if (pend_active) begin
            back = pend_up ? (cur <= slot_value(up_thr_reg, pend_rule))
                           : (cur >= slot_value(dn_thr_reg, pend_rule));
            if (back) begin
               // moved back across the pending threshold: search again from the origin
               hit = find_crossing(cur, pend_origin, rule, up);
               if (hit) begin
                  pend_up   = up;
                  pend_rule = rule;
               end else begin
                  pend_active = 1'b0;
               end
            end
         end
         last_sample = cur;
         if (pend_active) begin
            elapsed = now - deb_start;
            need = pend_up ? debounce_of(up_deb_reg, pend_rule)
                           : debounce_of(dn_deb_reg, pend_rule);
            if (elapsed >= {16'h0, need}) begin
               zone_now = pend_up ? target_of(up_meta_reg, pend_rule)
                                  : target_of(dn_meta_reg, pend_rule);
               pend_active = 1'b0;
            end
         end
      end else begin
         // a dropped sample pushes the debounce window later
         deb_start = deb_start + (now - last_tick);
      end
      last_tick   = now;
      rpt.zone    = zone_now;
      rpt.pending = pend_active;
      return rpt;
   endfunction

   task automatic offer_sample(input int value, input logic ok, input logic [31:0] now);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= 16'(value);
      req_sample_valid <= ok;
      req_now_ticks    <= now;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_reports.push_back(classify_sample(16'(value), ok, now));
      items_sent++;
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [63:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (which)
         CSR_UP_THR:     up_thr_reg = value;
         CSR_UP_DEB:     up_deb_reg = value;
         CSR_UP_META:    up_meta_reg = value[18:0];
         CSR_DN_THR:     dn_thr_reg = value;
         CSR_DN_DEB:     dn_deb_reg = value;
         CSR_DN_META:    dn_meta_reg = value[18:0];
         CSR_INIT_VALUE: begin
            init_value_reg = value[15:0];
            restart_channel();
         end
         CSR_INIT_ZONE: begin
            init_zone_reg = value[3:0];
            restart_channel();
         end
         default: ;
      endcase
      reg_writes++;
   endtask

   // half the samples land close to a configured threshold so crossings and returns happen
   task automatic offer_random_sample;
      int   pick, value;
      logic ok;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         value = int'(slot_value($urandom_range(0, 1) ? up_thr_reg : dn_thr_reg,
                                 $urandom_range(0, 3))) + int'($urandom_range(0, 400)) - 200;
      else if (pick < 80)
         value = int'(last_sample) + int'($urandom_range(0, 6000)) - 3000;
      else if (pick < 92)
         value = int'($urandom_range(0, 65535)) - 32768;
      else
         value = $urandom_range(0, 1) ? 32767 : -32768;
      if (value > 32767) value = 32767;
      if (value < -32768) value = -32768;
      ok = ($urandom_range(0, 99) < 85);
      pick = $urandom_range(0, 99);
      if (pick < 85)
         tick_now += $urandom_range(0, 12);
      else if (pick < 96)
         tick_now += $urandom_range(0, 70000);
      else
         tick_now = $urandom;
      offer_sample(value, ok, tick_now);
   endtask

   task automatic load_random_rules(input int kind);
      int          ups[$], dns[$];
      logic [63:0] up_deb, dn_deb, up_meta, dn_meta, start_value, start_zone;
      for (int i = 0; i < 4; i++) begin
         ups.push_back(int'($urandom_range(0, 40000)) - 20000);
         dns.push_back(int'($urandom_range(0, 40000)) - 20000);
      end
      if ($urandom_range(0, 4) != 0) begin
         ups.sort();
         dns.sort();
      end
      for (int i = 0; i < 4; i++) begin
         up_deb[16*i +: 16] = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 30))
                                                            : 16'($urandom);
         dn_deb[16*i +: 16] = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 30))
                                                            : 16'($urandom);
      end
      up_meta = meta_pack($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
      dn_meta = meta_pack($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
      // junk above the meta fields must be ignored
      if ($urandom_range(0, 3) == 0) up_meta[63:19] = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) dn_meta[63:19] = {$urandom, $urandom};
      start_value = {$urandom, $urandom};
      start_zone  = {$urandom, $urandom};
      if (kind == 0) begin
         ups = '{-32768, -1, 0, 32767};
         dns = '{-32768, -1, 0, 32767};
         up_deb = '0;
         dn_deb = '0;
         up_meta = meta_pack(4, 1, 2, 3, 4);
         dn_meta = meta_pack(4, 5, 6, 7, 8);
         start_value = 64'h8000;
         start_zone = '0;
      end else if (kind == 1) begin
         up_deb = '1;
         dn_deb = '1;
         up_meta = '1;
         dn_meta = '1;
         start_value = 64'h7FFF;
         start_zone = 64'hF;
      end
      write_reg(CSR_UP_THR, pack4(ups[0], ups[1], ups[2], ups[3]));
      write_reg(CSR_UP_DEB, up_deb);
      write_reg(CSR_UP_META, up_meta);
      write_reg(CSR_DN_THR, pack4(dns[0], dns[1], dns[2], dns[3]));
      write_reg(CSR_DN_DEB, dn_deb);
      write_reg(CSR_DN_META, dn_meta);
      write_reg(CSR_INIT_VALUE, start_value);
      write_reg(CSR_INIT_ZONE, start_zone);
   endtask

   // reset rules: one rule each way at zero with no debounce
   task automatic test_defaults;
      offer_sample(-32768, 1'b1, 32'd0);
      offer_sample(32767, 1'b1, 32'hFFFF_FFFF);
      offer_sample(0, 1'b0, 32'd5);
   endtask

   task automatic test_crossing_and_confirm;
      write_reg(CSR_UP_THR, pack4(-1000, 0, 1000, 20000));
      write_reg(CSR_UP_DEB, pack4(5, 10, 0, 100));
      write_reg(CSR_UP_META, meta_pack(4, 1, 2, 3, 4));
      write_reg(CSR_DN_THR, pack4(-20000, -5000, -3000, 1000));
      write_reg(CSR_DN_DEB, pack4(100, 0, 10, 5));
      write_reg(CSR_DN_META, meta_pack(4, 5, 6, 7, 8));
      write_reg(CSR_INIT_VALUE, 64'd0);
      write_reg(CSR_INIT_ZONE, 64'd0);
      offer_sample(1500, 1'b1, 32'd10);
      offer_sample(32767, 1'b1, 32'd11);
      offer_sample(32767, 1'b1, 32'd111);
      offer_sample(-32768, 1'b1, 32'd112);
      offer_sample(-32768, 1'b1, 32'd212);
   endtask

   task automatic test_move_back;
      offer_sample(500, 1'b1, 32'd300);
      // falls back under the pending threshold, lower rule takes over
      offer_sample(-500, 1'b1, 32'd304);
      offer_sample(-500, 1'b1, 32'd305);
      offer_sample(100, 1'b1, 32'd400);
      // back below the origin: transition dropped
      offer_sample(-800, 1'b1, 32'd401);
   endtask

   task automatic test_invalid_samples;
      offer_sample(25000, 1'b1, 32'hFFFF_FFC0);
      offer_sample(-32768, 1'b0, 32'hFFFF_FFF0);
      offer_sample(32767, 1'b0, 32'h0000_0010);
      offer_sample(25000, 1'b1, 32'h0000_0040);
      offer_sample(25000, 1'b1, 32'h0000_0080);
   endtask

   task automatic test_rule_counts;
      write_reg(CSR_UP_META, meta_pack(0, 1, 2, 3, 4));
      write_reg(CSR_DN_META, meta_pack(7, 9, 10, 11, 12));
      offer_sample(-30000, 1'b1, 32'd500);
      offer_sample(30000, 1'b1, 32'd501);
      write_reg(CSR_UP_META, meta_pack(4, 1, 2, 3, 4));
      offer_sample(-2000, 1'b1, 32'd510);
      offer_sample(-4000, 1'b1, 32'd511);
      // count shrinks under the pending rule, which still reads its own slot
      write_reg(CSR_DN_META, meta_pack(1, 9, 10, 11, 12));
      offer_sample(-3500, 1'b1, 32'd530);
   endtask

   task automatic test_unsorted_thresholds;
      write_reg(CSR_UP_THR, pack4(5000, -5000, 3000, -3000));
      offer_sample(6000, 1'b1, 32'd700);
      offer_sample(-6000, 1'b1, 32'd705);
   endtask

   task automatic test_restart;
      offer_sample(6000, 1'b1, 32'd710);
      write_reg(CSR_INIT_VALUE, 64'hA5A5_A5A5_A5A5_FF85);
      write_reg(CSR_INIT_ZONE, 64'hFFFF_FFFF_FFFF_FFF9);
      offer_sample(200, 1'b1, 32'd720);
   endtask

   task automatic test_backpressure;
      sender_gaps = 1'b0;
      receiver_stalls = 1'b1;
      long_hold = 150;
      repeat (16) offer_random_sample();
      wait_drained();
      repeat (8) offer_random_sample();
   endtask

   task automatic test_random_phases;
      for (int phase = 0; phase < 10; phase++) begin
         load_random_rules(phase);
         if (phase % 4 == 2) begin
            sender_gaps = 1'b0;
            receiver_stalls = 1'b0;
         end else begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 2) == 0) tick_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
         repeat (100) offer_random_sample();
      end
   endtask

   initial begin : response_checker
      int           hold;
      zone_report_t want;
      logic [3:0]   seen_zone;
      seen_zone = '0;
      forever begin
         hold = receiver_stalls ? $urandom_range(0, 6) : 0;
         if (long_hold > 0) begin
            hold = long_hold;
            long_hold = 0;
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expected_reports.size() == 0) begin
            $display("%0t: result with no item outstanding, zone %0d pending %0b",
                     $time, rsp_zone, rsp_debounce_pending);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_zone !== want.zone) begin
               $display("%0t: zone mismatch, expected %0d, got %0d", $time, want.zone, rsp_zone);
               mismatches++;
            end
            if (rsp_debounce_pending !== want.pending) begin
               $display("%0t: debounce_pending mismatch, expected %0b, got %0b",
                        $time, want.pending, rsp_debounce_pending);
               mismatches++;
            end
            results_checked++;
         end
         if (rsp_zone !== seen_zone) zone_changes++;
         seen_zone = rsp_zone;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time, expected_reports.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      up_thr_reg     = '0;
      up_deb_reg     = '0;
      up_meta_reg    = 19'd1;
      dn_thr_reg     = '0;
      dn_deb_reg     = '0;
      dn_meta_reg    = 19'd1;
      init_value_reg = '0;
      init_zone_reg  = '0;
      last_tick      = '0;
      pend_up        = 1'b0;
      pend_rule      = '0;
      pend_origin    = '0;
      deb_start      = '0;
      restart_channel();

      test_defaults();
      test_crossing_and_confirm();
      test_move_back();
      test_invalid_samples();
      test_rule_counts();
      test_unsorted_thresholds();
      test_restart();
      test_backpressure();
      test_random_phases();

      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      wait_drained();
      repeat (40) @(negedge clock);
      $display("covered %0d samples across %0d register writes: directed crossings, returns,",
               items_sent, reg_writes);
      $display("dropped samples, tick wrap, restarts, stalls; %0d results, %0d zone changes",
               results_checked, zone_changes);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
